>>> rtl/core/piecewise_table_interpolator_top_defines.svh
// Assertion macros shared by the interpolator RTL.
`ifndef PIECEWISE_TABLE_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_TABLE_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PTI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("pti: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PTI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("pti: next-cycle check failed");

`endif

>>> rtl/core/pti_pkg.sv
// Shared constants, types and state codes for the breakpoint table interpolator.
package pti_pkg;

  // Default geometry
  localparam int ENTRIES_DEF    = 16;
  localparam int DIMS_DEF       = 4;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed field widths
  localparam int TIME_BITS      = 32;
  localparam int ENTRY_IDX_BITS = 4;
  localparam int DIM_IDX_BITS   = 2;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 5;

  // Item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTERPOLATE = 1'b1;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_V0,
    ST_RD_V1,
    ST_DIFF,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/pti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pti_ram #(
  parameter int WIDTH = pti_pkg::TIME_BITS,
  parameter int DEPTH = pti_pkg::ENTRIES_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pti_div.sv
// Restoring divider, one quotient bit per cycle, for the blend quotient.
module pti_div #(
  parameter int Q_W = pti_pkg::VALUE_BITS_DEF + 1,
  parameter int D_W = pti_pkg::TIME_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [Q_W+D_W-1:0] num,
  input  logic [D_W-1:0]     den,
  output logic [Q_W-1:0]     quo,
  output pti_pkg::div_stat_t stat
);

  localparam int CW = $clog2(Q_W + 1);

  logic [D_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[Q_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // load: top bits are already below the divisor
      rem_nxt  = num[Q_W+D_W-1:Q_W];
      quo_nxt  = num[Q_W-1:0];
      cnt_nxt  = CW'(Q_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo_nxt = {quo_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset, datapath free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/core/piecewise_table_interpolator_top.sv
// Top level of the breakpoint table interpolator: sequencer, tables and output register.
//
// Input channel (in_valid / in_stall) carries one word per item. A load word
// (in_cmd = load) writes one breakpoint time and one value element in the
// cycle it is accepted; out-of-range indexes are dropped. A query word evaluates the
// table at in_query_time and yields one result word per dimension on the
// output channel (out_valid / out_stall), out_last marking the final one.
// out_status flags a table whose times in use decrease; those words carry 0.
// The block takes one item at a time: in_stall is high until a query is done.
// A query scans the entries in use through the time table's single read port,
// then per dimension reads one value in hold mode, or, when interpolating, reads
// two values, subtracts, multiplies and runs the bit-serial divider; a flagged
// table emits its words without reading values.
// A stalled receiver holds the output register and the sequencer waits there.
// Reset (rst_n low, synchronous) returns to idle, sets entry_count to 1 and
// hold mode; table contents are undefined until loaded.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
`include "piecewise_table_interpolator_top_defines.svh"

module piecewise_table_interpolator_top #(
  parameter int ENTRIES    = pti_pkg::ENTRIES_DEF,
  parameter int DIMS       = pti_pkg::DIMS_DEF,
  parameter int VALUE_BITS = pti_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [pti_pkg::ENTRY_IDX_BITS-1:0]  in_entry_index,
  input  logic [pti_pkg::DIM_IDX_BITS-1:0]    in_dim_index,
  input  logic signed [pti_pkg::TIME_BITS-1:0] in_entry_time,
  input  logic signed [VALUE_BITS-1:0]        in_entry_value,
  input  logic signed [pti_pkg::TIME_BITS-1:0] in_query_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [VALUE_BITS-1:0]        out_value,
  output logic [pti_pkg::DIM_IDX_BITS-1:0]    out_dim,
  output logic                                out_last,
  output logic                                out_status,
  input  logic                                cfg_we,
  input  logic [pti_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pti_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int TW    = pti_pkg::TIME_BITS;
  localparam int ODW   = pti_pkg::DIM_IDX_BITS;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int VA_W  = $clog2(ENTRIES * DIMS);
  localparam int A_W   = VALUE_BITS + 1;
  localparam int NUM_W = A_W + TW;

  // Configuration registers
  logic [pti_pkg::CFG_DATA_BITS-1:0] entry_count_r;
  logic                              interpolate_r;

  // Sequencer state
  pti_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]       next_addr_r, next_addr_nxt;
  logic                   rdv_r, rdv_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic signed [TW-1:0]   qt_r, qt_nxt;
  logic signed [TW-1:0]   prev_time_r, prev_time_nxt;
  logic                   prev_q_r, prev_q_nxt;
  logic                   bad_r, bad_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic signed [TW-1:0]   t0_r, t0_nxt;
  logic signed [TW-1:0]   t1_r, t1_nxt;
  logic                   has_next_r, has_next_nxt;
  logic [DIM_W-1:0]       dim_r, dim_nxt;
  logic [TW-1:0]          dt_r, dt_nxt;
  logic [TW-1:0]          span_r, span_nxt;
  logic [VALUE_BITS-1:0]  v0_r, v0_nxt;
  logic [A_W-1:0]         a_r, a_nxt;
  logic                   neg_r, neg_nxt;
  logic [NUM_W-1:0]       prod_r, prod_nxt;
  logic                   div_start_r, div_start_nxt;
  logic [VALUE_BITS-1:0]  res_r, res_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic [ODW-1:0]        out_dim_r, out_dim_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_status_r, out_status_nxt;

  // Memory ports
  logic                  tram_we, tram_re;
  logic [IDX_W-1:0]      tram_waddr, tram_raddr;
  logic [TW-1:0]         tram_rdata;
  logic                  vram_we, vram_re;
  logic [VA_W-1:0]       vram_waddr, vram_raddr;
  logic [VALUE_BITS-1:0] vram_rdata;

  // Divider
  logic [A_W-1:0]        div_quo;
  pti_pkg::div_stat_t    div_stat;

  // Combinational helpers
  logic [CNT_W-1:0]      n_eff;
  logic                  load_ok;
  logic signed [TW-1:0]  td;
  logic                  td_le;
  logic [VA_W-1:0]       vbase;
  logic [A_W-1:0]        dv;
  logic [A_W:0]          v0x;
  logic [A_W:0]          blend_sum;

  // Clamp the entry count into 1..ENTRIES
  always_comb begin
    if (entry_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(entry_count_r) > 32'(ENTRIES)) begin
      n_eff = CNT_W'(ENTRIES);
    end else begin
      n_eff = CNT_W'(entry_count_r);
    end
  end

  assign in_stall = (state_r != pti_pkg::ST_IDLE);

  // Load path: both tables written in the accept cycle
  assign load_ok    = (32'(in_entry_index) < 32'(ENTRIES)) && (32'(in_dim_index) < 32'(DIMS));
  assign tram_we    = in_valid && !in_stall && (in_cmd == pti_pkg::CMD_LOAD) && load_ok;
  assign vram_we    = tram_we;
  assign tram_waddr = IDX_W'(in_entry_index);
  assign vram_waddr = VA_W'(VA_W'(in_entry_index) * VA_W'(DIMS)) + VA_W'(in_dim_index);

  // Scan datapath
  assign td    = signed'(tram_rdata);
  assign td_le = (td <= qt_r);

  // Value addressing and blend arithmetic
  assign vbase     = VA_W'(VA_W'(idx_r) * VA_W'(DIMS));
  assign dv        = {vram_rdata[VALUE_BITS-1], vram_rdata} - {v0_r[VALUE_BITS-1], v0_r};
  assign v0x       = {{2{v0_r[VALUE_BITS-1]}}, v0_r};
  assign blend_sum = neg_r ? (v0x - {1'b0, div_quo}) : (v0x + {1'b0, div_quo});

  // Read port selection
  always_comb begin
    tram_re    = 1'b0;
    tram_raddr = next_addr_r[IDX_W-1:0];
    vram_re    = 1'b0;
    vram_raddr = vbase + VA_W'(dim_r);
    case (state_r)
      pti_pkg::ST_IDLE: begin
        tram_re    = in_valid && (in_cmd == pti_pkg::CMD_QUERY);
        tram_raddr = '0;
      end
      pti_pkg::ST_SCAN: begin
        tram_re = (next_addr_r < n_eff);
      end
      pti_pkg::ST_RD_V0: begin
        vram_re = !bad_r;
      end
      pti_pkg::ST_RD_V1: begin
        vram_re    = interpolate_r && has_next_r;
        vram_raddr = vbase + VA_W'(DIMS) + VA_W'(dim_r);
      end
      default: begin
      end
    endcase
  end

  // Next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    next_addr_nxt  = next_addr_r;
    rdv_nxt        = rdv_r;
    rd_idx_nxt     = rd_idx_r;
    qt_nxt         = qt_r;
    prev_time_nxt  = prev_time_r;
    prev_q_nxt     = prev_q_r;
    bad_nxt        = bad_r;
    idx_nxt        = idx_r;
    t0_nxt         = t0_r;
    t1_nxt         = t1_r;
    has_next_nxt   = has_next_r;
    dim_nxt        = dim_r;
    dt_nxt         = dt_r;
    span_nxt       = span_r;
    v0_nxt         = v0_r;
    a_nxt          = a_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    div_start_nxt  = 1'b0;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_dim_nxt    = out_dim_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    case (state_r)
      pti_pkg::ST_IDLE: begin
        // start a query: entry 0 is being read
        if (in_valid && (in_cmd == pti_pkg::CMD_QUERY)) begin
          qt_nxt        = in_query_time;
          rdv_nxt       = 1'b1;
          rd_idx_nxt    = '0;
          next_addr_nxt = CNT_W'(1);
          bad_nxt       = 1'b0;
          prev_q_nxt    = 1'b0;
          has_next_nxt  = 1'b0;
          idx_nxt       = '0;
          state_nxt     = pti_pkg::ST_SCAN;
        end
      end

      pti_pkg::ST_SCAN: begin
        // keep one time read in flight per cycle
        if (next_addr_r < n_eff) begin
          rdv_nxt       = 1'b1;
          rd_idx_nxt    = next_addr_r[IDX_W-1:0];
          next_addr_nxt = next_addr_r + 1'b1;
        end else begin
          rdv_nxt = 1'b0;
        end
        if (rdv_r) begin
          // flag decreasing times
          if ((rd_idx_r != '0) && (td < prev_time_r)) begin
            bad_nxt = 1'b1;
          end
          prev_time_nxt = td;
          prev_q_nxt    = td_le;
          // track the last entry not above the query and its successor
          if (td_le) begin
            idx_nxt      = rd_idx_r;
            t0_nxt       = td;
            has_next_nxt = 1'b0;
          end else if (prev_q_r) begin
            t1_nxt       = td;
            has_next_nxt = 1'b1;
          end
          if (CNT_W'(rd_idx_r) == (n_eff - 1'b1)) begin
            dim_nxt   = '0;
            state_nxt = pti_pkg::ST_RD_V0;
          end
        end
      end

      pti_pkg::ST_RD_V0: begin
        dt_nxt   = TW'(qt_r - t0_r);
        span_nxt = TW'(t1_r - t0_r);
        if (bad_r) begin
          res_nxt   = '0;
          state_nxt = pti_pkg::ST_EMIT;
        end else begin
          state_nxt = pti_pkg::ST_RD_V1;
        end
      end

      pti_pkg::ST_RD_V1: begin
        v0_nxt = vram_rdata;
        if (interpolate_r && has_next_r) begin
          state_nxt = pti_pkg::ST_DIFF;
        end else begin
          res_nxt   = vram_rdata;
          state_nxt = pti_pkg::ST_EMIT;
        end
      end

      pti_pkg::ST_DIFF: begin
        // magnitude and sign of v1 - v0
        neg_nxt   = dv[A_W-1];
        a_nxt     = dv[A_W-1] ? (~dv + 1'b1) : dv;
        state_nxt = pti_pkg::ST_MUL;
      end

      pti_pkg::ST_MUL: begin
        prod_nxt      = a_r * dt_r;
        div_start_nxt = 1'b1;
        state_nxt     = pti_pkg::ST_DIV;
      end

      pti_pkg::ST_DIV: begin
        if (div_stat.done) begin
          res_nxt   = blend_sum[VALUE_BITS-1:0];
          state_nxt = pti_pkg::ST_EMIT;
        end
      end

      pti_pkg::ST_EMIT: begin
        // hand over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_r;
          out_dim_nxt    = ODW'(dim_r);
          out_last_nxt   = (dim_r == DIM_W'(DIMS - 1));
          out_status_nxt = bad_r ? pti_pkg::STATUS_BAD : pti_pkg::STATUS_OK;
          if (dim_r == DIM_W'(DIMS - 1)) begin
            state_nxt = pti_pkg::ST_IDLE;
          end else begin
            dim_nxt   = dim_r + 1'b1;
            state_nxt = pti_pkg::ST_RD_V0;
          end
        end
      end

      default: begin
        state_nxt = pti_pkg::ST_IDLE;
      end
    endcase
  end

  // Register control under reset, payload without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pti_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      div_start_r   <= 1'b0;
      rdv_r         <= 1'b0;
      entry_count_r <= pti_pkg::CFG_DATA_BITS'(1);
      interpolate_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= div_start_nxt;
      rdv_r       <= rdv_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pti_pkg::REG_ENTRY_COUNT: entry_count_r <= cfg_wdata;
          pti_pkg::REG_INTERPOLATE: interpolate_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
    next_addr_r  <= next_addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    qt_r         <= qt_nxt;
    prev_time_r  <= prev_time_nxt;
    prev_q_r     <= prev_q_nxt;
    bad_r        <= bad_nxt;
    idx_r        <= idx_nxt;
    t0_r         <= t0_nxt;
    t1_r         <= t1_nxt;
    has_next_r   <= has_next_nxt;
    dim_r        <= dim_nxt;
    dt_r         <= dt_nxt;
    span_r       <= span_nxt;
    v0_r         <= v0_nxt;
    a_r          <= a_nxt;
    neg_r        <= neg_nxt;
    prod_r       <= prod_nxt;
    res_r        <= res_nxt;
    out_value_r  <= out_value_nxt;
    out_dim_r    <= out_dim_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = signed'(out_value_r);
  assign out_dim    = out_dim_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  // Breakpoint time table
  pti_ram #(
    .WIDTH (TW),
    .DEPTH (ENTRIES)
  ) u_time_ram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (tram_waddr),
    .wdata (in_entry_time),
    .re    (tram_re),
    .raddr (tram_raddr),
    .rdata (tram_rdata)
  );

  // Breakpoint value table, entry-major
  pti_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES * DIMS)
  ) u_value_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (in_entry_value),
    .re    (vram_re),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  // Blend quotient (|v1-v0| * dt) / span
  pti_div #(
    .Q_W (A_W),
    .D_W (TW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (prod_r),
    .den   (span_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  `PTI_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_stat.done, state_r == pti_pkg::ST_DIV)
  `PTI_ASSERT_IMP(a_div_idle_in_emit, clk, rst_n, state_r == pti_pkg::ST_EMIT, !div_stat.busy)
  `PTI_ASSERT_NXT(a_query_scans, clk, rst_n, in_valid && !in_stall && (in_cmd == pti_pkg::CMD_QUERY), state_r == pti_pkg::ST_SCAN)
  `PTI_ASSERT_IMP(a_bad_reads_zero, clk, rst_n, out_valid && (out_status == pti_pkg::STATUS_BAD), out_value == '0)
  `PTI_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, vram_we || tram_we, !vram_re && !tram_re)

endmodule

>>> tb/piecewise_table_interpolator_top_tb.sv
// Self-checking testbench for the breakpoint table interpolator: load and query words.
`timescale 1ns / 1ps

module piecewise_table_interpolator_top_tb;
  import pti_pkg::*;

  localparam int NUM_ENTRIES   = ENTRIES_DEF;
  localparam int NUM_DIMS      = DIMS_DEF;
  localparam int VBITS         = VALUE_BITS_DEF;
  localparam int MAX_COUNT     = (1 << CFG_DATA_BITS) - 1;
  localparam int RANDOM_WORDS  = 440;
  localparam int STEADY_WORDS  = 60;
  localparam int CFG_SETTLE    = 20;
  localparam int END_SETTLE    = 120;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic                        cmd;
    logic [ENTRY_IDX_BITS-1:0]   entry_index;
    logic [DIM_IDX_BITS-1:0]     dim_index;
    logic signed [TIME_BITS-1:0] entry_time;
    logic signed [VBITS-1:0]     entry_value;
    logic signed [TIME_BITS-1:0] query_time;
  } item_word_t;

  typedef struct packed {
    logic signed [VBITS-1:0]     value;
    logic [DIM_IDX_BITS-1:0]     dim;
    logic                        last;
    logic                        status;
  } sample_word_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_cmd;
  logic [ENTRY_IDX_BITS-1:0]   in_entry_index;
  logic [DIM_IDX_BITS-1:0]     in_dim_index;
  logic signed [TIME_BITS-1:0] in_entry_time;
  logic signed [VBITS-1:0]     in_entry_value;
  logic signed [TIME_BITS-1:0] in_query_time;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [VBITS-1:0]     out_value;
  logic [DIM_IDX_BITS-1:0]     out_dim;
  logic                        out_last;
  logic                        out_status;
  logic                        cfg_we;
  logic [CFG_IDX_BITS-1:0]     cfg_index;
  logic [CFG_DATA_BITS-1:0]    cfg_wdata;

  // Shadow copy of the breakpoint tables and registers
  logic signed [TIME_BITS-1:0] bp_time [NUM_ENTRIES];
  logic signed [VBITS-1:0]     bp_value [NUM_ENTRIES][NUM_DIMS];
  logic [NUM_DIMS-1:0]         bp_loaded [NUM_ENTRIES];
  logic [CFG_DATA_BITS-1:0]    cur_count = 1;
  logic                        cur_interp = 1'b0;

  sample_word_t expected_samples [$];
  int mismatches  = 0;
  int words_sent  = 0;
  int quiet_count = 0;
  bit idling_on   = 1'b1;

  piecewise_table_interpolator_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_entry_index (in_entry_index),
    .in_dim_index   (in_dim_index),
    .in_entry_time  (in_entry_time),
    .in_entry_value (in_entry_value),
    .in_query_time  (in_query_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_dim        (out_dim),
    .out_last       (out_last),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Clamp the entry count register to the entries actually scanned
  function automatic int active_entries();
    if (cur_count == 0) return 1;
    if (cur_count > NUM_ENTRIES) return NUM_ENTRIES;
    return int'(cur_count);
  endfunction

  // Evaluate the table at one query time and queue one word per dimension
  function automatic void interpolate_at(logic signed [TIME_BITS-1:0] t);
    int n;
    int sel;
    bit bad;
    longint tq, t0, t1, v0, v1, dv, mag, res;
    sample_word_t w;
    n = active_entries();
    bad = 1'b0;
    sel = 0;
    tq = t;
    for (int i = 1; i < n; i++)
      if (bp_time[i] < bp_time[i-1]) bad = 1'b1;
    // pick the last breakpoint at or below the query
    if (!bad && tq >= bp_time[0])
      for (int i = 0; i < n; i++)
        if (bp_time[i] <= tq) sel = i;
    for (int d = 0; d < NUM_DIMS; d++) begin
      res = 0;
      if (!bad) begin
        res = bp_value[sel][d];
        if (cur_interp && sel + 1 < n) begin
          t0 = bp_time[sel];
          t1 = bp_time[sel+1];
          if (tq >= t0 && tq < t1) begin
            v0 = bp_value[sel][d];
            v1 = bp_value[sel+1][d];
            dv = v1 - v0;
            // magnitude first, so the quotient truncates toward zero
            mag = ((dv < 0) ? -dv : dv) * (tq - t0) / (t1 - t0);
            res = (dv < 0) ? v0 - mag : v0 + mag;
          end
        end
      end
      w.value  = res[VBITS-1:0];
      w.dim    = d[DIM_IDX_BITS-1:0];
      w.last   = (d == NUM_DIMS - 1);
      w.status = bad ? STATUS_BAD : STATUS_OK;
      expected_samples.push_back(w);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Drive one word, hold it until taken, then update the shadow state
  task automatic send_word(item_word_t w);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= w.cmd;
    in_entry_index <= w.entry_index;
    in_dim_index   <= w.dim_index;
    in_entry_time  <= w.entry_time;
    in_entry_value <= w.entry_value;
    in_query_time  <= w.query_time;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.cmd == CMD_LOAD) begin
      bp_time[w.entry_index] = w.entry_time;
      bp_value[w.entry_index][w.dim_index] = w.entry_value;
      bp_loaded[w.entry_index][w.dim_index] = 1'b1;
    end else begin
      interpolate_at(w.query_time);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic load_element(int e, int d, logic signed [TIME_BITS-1:0] t,
                              logic signed [VBITS-1:0] v);
    item_word_t w;
    w.cmd         = CMD_LOAD;
    w.entry_index = e[ENTRY_IDX_BITS-1:0];
    w.dim_index   = d[DIM_IDX_BITS-1:0];
    w.entry_time  = t;
    w.entry_value = v;
    w.query_time  = $urandom;
    send_word(w);
  endtask

  task automatic query_at(logic signed [TIME_BITS-1:0] t);
    item_word_t w;
    w.cmd         = CMD_QUERY;
    w.entry_index = $urandom_range(0, NUM_ENTRIES - 1);
    w.dim_index   = $urandom_range(0, NUM_DIMS - 1);
    w.entry_time  = $urandom;
    w.entry_value = $urandom;
    w.query_time  = t;
    send_word(w);
  endtask

  // Drop valid, drain all results, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
  endtask

  // Write both registers, entry count then interpolate flag, while idle
  task automatic set_config(logic [CFG_DATA_BITS-1:0] count, logic interp);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENTRY_COUNT;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_index <= REG_INTERPOLATE;
    cfg_wdata <= CFG_DATA_BITS'(interp);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_count  = count;
    cur_interp = interp;
  endtask

  function automatic logic signed [VBITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [TIME_BITS-1:0] pick_query_time(int n);
    int i;
    longint lo, span;
    logic signed [TIME_BITS-1:0] r;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0: r = bp_time[i];
      1: r = bp_time[i] - 1;
      2: r = bp_time[i] + 1;
      3, 4, 5: begin
        lo = bp_time[i];
        span = (i + 1 < n) ? longint'(bp_time[i+1]) - lo : 0;
        if (span > 0) lo = lo + longint'($urandom) % span;
        r = lo[TIME_BITS-1:0];
      end
      6: r = bp_time[0] - $urandom_range(1, 1000);
      7: r = 32'sh7fffffff;
      8: r = 32'sh80000000;
      default: r = $urandom;
    endcase
    return r;
  endfunction

  // Write every element of entries 0..n-1, times non-decreasing unless broken is set
  task automatic load_table(int n, bit broken);
    logic signed [TIME_BITS-1:0] times [NUM_ENTRIES];
    logic signed [TIME_BITS-1:0] t;
    longint cur, step;
    int perm [NUM_DIMS];
    int j, tmp;
    case ($urandom_range(0, 3))
      0:       cur = -64'sd2147483648;
      1:       cur = longint'($urandom_range(0, 2000)) - 1000;
      default: cur = longint'(int'($urandom));
    endcase
    for (int e = 0; e < n; e++) begin
      if (e > 0) begin
        case ($urandom_range(0, 4))
          0:       step = 0;
          1:       step = 1;
          2:       step = $urandom_range(2, 100);
          3:       step = $urandom_range(101, 1 << 20);
          default: step = $urandom >> 3;
        endcase
        cur = cur + step;
        if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      end
      times[e] = cur[TIME_BITS-1:0];
    end
    // break the ordering at one entry
    if (broken && n > 1) begin
      j = $urandom_range(1, n - 1);
      if (times[j-1] > -32'sd2147483000) times[j] = times[j-1] - $urandom_range(1, 1000);
      else times[j-1] = 32'sh7fffffff;
    end
    for (int e = 0; e < n; e++) begin
      for (int k = 0; k < NUM_DIMS; k++) perm[k] = k;
      for (int k = NUM_DIMS - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = perm[k];
        perm[k] = perm[j];
        perm[j] = tmp;
      end
      // earlier words of an entry may carry a stray time; the last one sets it
      for (int k = 0; k < NUM_DIMS; k++) begin
        t = times[e];
        if (k < NUM_DIMS - 1 && $urandom_range(0, 7) == 0) t = $urandom;
        load_element(e, perm[k], t, pick_value());
      end
    end
  endtask

  // One setting of the registers, a table, then a run of queries
  task automatic run_phase();
    logic [CFG_DATA_BITS-1:0] count;
    int n, kind, nq;
    bit ready;
    case ($urandom_range(0, 15))
      0:       count = 0;
      1:       count = 1;
      2:       count = NUM_ENTRIES;
      3:       count = MAX_COUNT;
      4:       count = $urandom_range(NUM_ENTRIES + 1, MAX_COUNT - 1);
      default: count = $urandom_range(2, 6);
    endcase
    set_config(count, $urandom_range(0, 1));
    n = active_entries();
    ready = 1'b1;
    for (int e = 0; e < n; e++)
      if (bp_loaded[e] != '1) ready = 1'b0;
    kind = $urandom_range(0, 9);
    if (!ready || kind < 6) load_table(n, 1'b0);
    else if (kind < 8) load_table(n, 1'b1);
    nq = $urandom_range(6, 14);
    for (int q = 0; q < nq; q++) begin
      // occasional stray load between queries
      if ($urandom_range(0, 9) == 0)
        load_element($urandom_range(0, NUM_ENTRIES - 1), $urandom_range(0, NUM_DIMS - 1),
                     $urandom, pick_value());
      query_at(pick_query_time(n));
    end
  endtask

  // Single entry after reset: every query returns that entry
  task automatic test_single_entry();
    load_element(0, 2, 0, 16'sh7fff);
    load_element(0, 0, 0, 16'sh8000);
    load_element(0, 3, 0, 0);
    load_element(0, 1, 0, 1234);
    query_at(32'sh80000000);
    query_at(32'sh7fffffff);
    query_at(0);
  endtask

  // Two entries with blending: below, on, between and beyond the breakpoints
  task automatic test_two_entry_blend();
    set_config(2, 1'b1);
    load_element(1, 0, 1000, 16'sh7fff);
    load_element(1, 1, 1000, 16'sh8000);
    load_element(1, 2, 1000, 100);
    load_element(1, 3, 1000, -7);
    query_at(-5);
    query_at(0);
    query_at(500);
    query_at(999);
    query_at(1000);
    query_at(32'sh7fffffff);
  endtask

  // Equal breakpoint times, then a decreasing pair
  task automatic test_equal_and_decreasing();
    load_element(1, 0, 0, 16'sh7fff);
    query_at(0);
    load_element(1, 0, -1, 16'sh7fff);
    query_at(0);
  endtask

  // Entry count of zero scans a single entry
  task automatic test_count_zero();
    set_config(0, 1'b0);
    query_at(12345);
  endtask

  task automatic test_random_traffic();
    idling_on = 1'b1;
    while (words_sent < RANDOM_WORDS) run_phase();
  endtask

  // Last stretch with no idling on either side
  task automatic test_steady_stream();
    int target;
    idling_on = 1'b0;
    target = words_sent + STEADY_WORDS;
    while (words_sent < target) run_phase();
  endtask

  // Random receiver stall bursts, started only while idling is on
  initial begin : stall_gen
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : check_words
    sample_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result word", out_value, 0);
      end else begin
        want = expected_samples.pop_front();
        if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
        if (out_dim !== want.dim) report_mismatch("out_dim", out_dim, want.dim);
        if (out_last !== want.last) report_mismatch("out_last", out_last, want.last);
        if (out_status !== want.status) report_mismatch("out_status", out_status, want.status);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("piecewise_table_interpolator_top_tb NOT OK");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_LOAD;
    in_entry_index = '0;
    in_dim_index   = '0;
    in_entry_time  = '0;
    in_entry_value = '0;
    in_query_time  = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_ENTRY_COUNT;
    cfg_wdata      = '0;
    for (int e = 0; e < NUM_ENTRIES; e++) bp_loaded[e] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_single_entry();
    test_two_entry_blend();
    test_equal_and_decreasing();
    test_count_zero();
    test_random_traffic();
    test_steady_stream();

    // Drain, then watch for stray words
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (END_SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("piecewise_table_interpolator_top_tb OK");
    end else begin
      $display("piecewise_table_interpolator_top_tb NOT OK");
    end
    $finish;
  end

endmodule
